### rtl/mvpl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MAC vendor prefix lookup package
// Shared types, codes and helper functions for the prefix lookup block.
// ----------------------------------------------------------------------------
package mvpl_pkg;

  localparam int MacW     = 48;
  localparam int PrefixW  = 36;
  localparam int SlotW    = 6;
  localparam int VendorW  = 16;
  localparam int LenW     = 2;
  localparam int RankW    = 3;

  // Beat widths on the streams
  localparam int InDataW  = 112;
  localparam int OutDataW = 24;
  localparam int StatusW  = 2;

  // First-byte flag positions in the address
  localparam int McastBit = 40;
  localparam int LocalBit = 41;

  // Request kinds
  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  // Result status codes
  localparam logic [StatusW-1:0] STATUS_WRITE_DONE = 2'd0;
  localparam logic [StatusW-1:0] STATUS_UNKNOWN    = 2'd1;
  localparam logic [StatusW-1:0] STATUS_PRIVATE    = 2'd2;
  localparam logic [StatusW-1:0] STATUS_FOUND      = 2'd3;

  // Prefix length codes
  localparam logic [LenW-1:0] LEN_EMPTY = 2'd0;
  localparam logic [LenW-1:0] LEN_24    = 2'd1;
  localparam logic [LenW-1:0] LEN_28    = 2'd2;
  localparam logic [LenW-1:0] LEN_36    = 2'd3;

  typedef struct packed {
    logic [PrefixW-1:0] prefix;
    logic [LenW-1:0]    length;
    logic               custom;
    logic [VendorW-1:0] vendor;
  } entry_t;

  typedef struct packed {
    logic               found;
    logic [VendorW-1:0] vendor;
    logic [LenW-1:0]    length;
    logic               custom;
  } best_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESP
  } state_e;

  // Significant prefix bits for a length code
  function automatic logic [PrefixW-1:0] prefix_mask(input logic [LenW-1:0] len);
    logic [PrefixW-1:0] m;
    case (len)
      LEN_36:  m = {36{1'b1}};
      LEN_28:  m = {{28{1'b1}}, 8'd0};
      LEN_24:  m = {{24{1'b1}}, 12'd0};
      default: m = '0;
    endcase
    return m;
  endfunction

  // Search priority: custom 36/28/24 above built-in 36/28/24, empty lowest
  function automatic logic [RankW-1:0] entry_rank(input logic [LenW-1:0] len,
                                                  input logic custom);
    logic [RankW-1:0] r;
    if (len == LEN_EMPTY) begin
      r = '0;
    end else if (custom) begin
      r = {1'b0, len} + 3'd3;
    end else begin
      r = {1'b0, len};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/mvpl_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Prefix table memory
// One write port and one registered read port over the slot entries.
// ----------------------------------------------------------------------------
module mvpl_table #(
  parameter int TABLE_DEPTH = 64,
  parameter int AddrW       = 6
) (
  input  wire logic                   clk_i,
  input  wire logic                   we_i,
  input  wire logic [AddrW-1:0]       waddr_i,
  input  wire mvpl_pkg::entry_t       wdata_i,
  input  wire logic [AddrW-1:0]       raddr_i,
  output mvpl_pkg::entry_t            rdata_o
);

  mvpl_pkg::entry_t mem [TABLE_DEPTH];
  mvpl_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### rtl/mvpl_match.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Prefix compare unit
// Compares one table entry a cycle against the address and keeps the best hit.
// ----------------------------------------------------------------------------
module mvpl_match (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              clear_i,
  input  wire logic                              en_i,
  input  wire logic [mvpl_pkg::PrefixW-1:0]      mac_hi_i,
  input  wire mvpl_pkg::entry_t                  entry_i,
  output mvpl_pkg::best_t                        best_o
);

  logic [mvpl_pkg::RankW-1:0]   rank_q, rank_d;
  logic [mvpl_pkg::RankW-1:0]   cand_rank;
  logic                         hit;
  logic                         take;
  logic [mvpl_pkg::VendorW-1:0] vendor_q, vendor_d;
  logic [mvpl_pkg::LenW-1:0]    length_q, length_d;
  logic                         custom_q, custom_d;

  always_comb begin
    hit = (entry_i.length != mvpl_pkg::LEN_EMPTY) &&
          (((mac_hi_i ^ entry_i.prefix) & mvpl_pkg::prefix_mask(entry_i.length)) == '0);
    cand_rank = mvpl_pkg::entry_rank(entry_i.length, entry_i.custom);
    // strictly better only, so the lowest slot wins a tie
    take = en_i && hit && (cand_rank > rank_q);

    rank_d   = rank_q;
    vendor_d = vendor_q;
    length_d = length_q;
    custom_d = custom_q;
    if (clear_i) begin
      rank_d = '0;
    end else if (take) begin
      rank_d   = cand_rank;
      vendor_d = entry_i.vendor;
      length_d = entry_i.length;
      custom_d = entry_i.custom;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q <= '0;
    end else begin
      rank_q <= rank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vendor_q <= vendor_d;
    length_q <= length_d;
    custom_q <= custom_d;
  end

  assign best_o.found  = (rank_q != '0);
  assign best_o.vendor = vendor_q;
  assign best_o.length = length_q;
  assign best_o.custom = custom_q;

endmodule
`default_nettype wire

### rtl/mac_vendor_prefix_lookup_top.sv
`timescale 1ns / 1ps
`default_nettype none
// A write beat, or a lookup of a zero, multicast or locally administered
// address, is answered straight into the output register. Any other lookup
// scans every slot through the single compare unit, one slot a cycle.
// One item at a time; the next beat is taken once the output register is
// empty or being read. After reset the table is swept to empty, slot by
// slot, with no beat accepted.
// ----------------------------------------------------------------------------
// MAC vendor prefix lookup
// Prefix table with write and longest-prefix lookup requests on streams.
// ----------------------------------------------------------------------------
module mac_vendor_prefix_lookup_top #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // mac[47:0], slot_index[53:48], entry_prefix[89:54], entry_length[91:90],
  // entry_custom[92], entry_vendor[108:93], zero[111:109]
  input  wire logic [mvpl_pkg::InDataW-1:0]      s_axis_tdata_i,
  // req_type[0]
  input  wire logic                              s_axis_tuser_i,
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // vendor_id[15:0], match_length[17:16], match_custom[18], zero[23:19]
  output logic [mvpl_pkg::OutDataW-1:0]          m_axis_tdata_o,
  // status[1:0]
  output logic [mvpl_pkg::StatusW-1:0]           m_axis_tuser_o
);

  localparam int AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int IdxW  = (AddrW > mvpl_pkg::SlotW) ? AddrW : mvpl_pkg::SlotW;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(TABLE_DEPTH - 1);

  mvpl_pkg::state_e state_q, state_d;
  logic [AddrW-1:0] cnt_q, cnt_d;
  logic             rd_vld_q, rd_vld_d;
  logic [mvpl_pkg::PrefixW-1:0] mac_q, mac_d;

  logic                         out_vld_q, out_vld_d;
  logic [mvpl_pkg::StatusW-1:0] out_status_q, out_status_d;
  logic [mvpl_pkg::VendorW-1:0] out_vendor_q, out_vendor_d;
  logic [mvpl_pkg::LenW-1:0]    out_length_q, out_length_d;
  logic                         out_custom_q, out_custom_d;

  // Beat fields
  logic [mvpl_pkg::MacW-1:0]    in_mac;
  logic [mvpl_pkg::SlotW-1:0]   in_slot;
  mvpl_pkg::entry_t             in_entry;
  logic [IdxW-1:0]              slot_ext;
  logic                         slot_ok;

  logic             out_free;
  logic             accept;
  logic             we;
  logic [AddrW-1:0] waddr;
  mvpl_pkg::entry_t wdata;
  logic [AddrW-1:0] raddr;
  logic             match_clear;
  mvpl_pkg::entry_t rdata;
  mvpl_pkg::best_t  best;

  assign in_mac          = s_axis_tdata_i[47:0];
  assign in_slot         = s_axis_tdata_i[53:48];
  assign in_entry.prefix = s_axis_tdata_i[89:54];
  assign in_entry.length = s_axis_tdata_i[91:90];
  assign in_entry.custom = s_axis_tdata_i[92];
  assign in_entry.vendor = s_axis_tdata_i[108:93];

  assign slot_ext = IdxW'(in_slot);
  assign slot_ok  = (32'(in_slot) < 32'(TABLE_DEPTH));

  assign out_free = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == mvpl_pkg::ST_IDLE) && out_free;
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    rd_vld_d     = 1'b0;
    mac_d        = mac_q;
    we           = 1'b0;
    waddr        = slot_ext[AddrW-1:0];
    wdata        = in_entry;
    raddr        = cnt_q;
    match_clear  = 1'b0;
    out_vld_d    = out_vld_q && !m_axis_tready_i;
    out_status_d = out_status_q;
    out_vendor_d = out_vendor_q;
    out_length_d = out_length_q;
    out_custom_d = out_custom_q;

    case (state_q)
      mvpl_pkg::ST_CLEAR: begin
        // sweep every slot to empty
        we    = 1'b1;
        waddr = cnt_q;
        wdata = '0;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastAddr) begin
          cnt_d   = '0;
          state_d = mvpl_pkg::ST_IDLE;
        end
      end
      mvpl_pkg::ST_IDLE: begin
        if (accept) begin
          out_vendor_d = '0;
          out_length_d = mvpl_pkg::LEN_EMPTY;
          out_custom_d = 1'b0;
          if (s_axis_tuser_i == mvpl_pkg::REQ_WRITE) begin
            we           = slot_ok;
            out_vld_d    = 1'b1;
            out_status_d = mvpl_pkg::STATUS_WRITE_DONE;
          end else if ((in_mac == '0) || in_mac[mvpl_pkg::McastBit]) begin
            out_vld_d    = 1'b1;
            out_status_d = mvpl_pkg::STATUS_UNKNOWN;
          end else if (in_mac[mvpl_pkg::LocalBit]) begin
            out_vld_d    = 1'b1;
            out_status_d = mvpl_pkg::STATUS_PRIVATE;
          end else begin
            mac_d       = in_mac[47:12];
            match_clear = 1'b1;
            cnt_d       = '0;
            state_d     = mvpl_pkg::ST_SCAN;
          end
        end
      end
      mvpl_pkg::ST_SCAN: begin
        rd_vld_d = 1'b1;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == LastAddr) begin
          cnt_d   = '0;
          state_d = mvpl_pkg::ST_DRAIN;
        end
      end
      mvpl_pkg::ST_DRAIN: begin
        // last slot is compared on this edge
        state_d = mvpl_pkg::ST_RESP;
      end
      mvpl_pkg::ST_RESP: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          if (best.found) begin
            out_status_d = mvpl_pkg::STATUS_FOUND;
            out_vendor_d = best.vendor;
            out_length_d = best.length;
            out_custom_d = best.custom;
          end else begin
            out_status_d = mvpl_pkg::STATUS_UNKNOWN;
            out_vendor_d = '0;
            out_length_d = mvpl_pkg::LEN_EMPTY;
            out_custom_d = 1'b0;
          end
          state_d = mvpl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mvpl_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mvpl_pkg::ST_CLEAR;
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mac_q        <= mac_d;
    out_status_q <= out_status_d;
    out_vendor_q <= out_vendor_d;
    out_length_q <= out_length_d;
    out_custom_q <= out_custom_d;
  end

  mvpl_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AddrW       (AddrW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  mvpl_match u_match (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clear_i  (match_clear),
    .en_i     (rd_vld_q),
    .mac_hi_i (mac_q),
    .entry_i  (rdata),
    .best_o   (best)
  );

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {5'd0, out_custom_q, out_length_q, out_vendor_q};

endmodule
`default_nettype wire
